// File: sv/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared widths, opcodes and sequencer state codes of the grid slot cache.
// ----------------------------------------------------------------------------
`default_nettype none

package gsc_pkg;

    // Working width of grid values (indices, rows, distances).
    localparam int VAL_W = 14;

    localparam logic [1:0] OP_INSTALL = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_PICK    = 2'd2;

    localparam logic [2:0] ADDR_ITEM_COUNT = 3'd0;

    typedef enum logic [10:0] {
        ST_CLEAR    = 11'b000_0000_0001,
        ST_IDLE     = 11'b000_0000_0010,
        ST_MAP_CHK  = 11'b000_0000_0100,
        ST_SEL_DIV  = 11'b000_0000_1000,
        ST_SCAN_GO  = 11'b000_0001_0000,
        ST_SCAN_DIV = 11'b000_0010_0000,
        ST_EVICT    = 11'b000_0100_0000,
        ST_INSTALL  = 11'b000_1000_0000,
        ST_PICK     = 11'b001_0000_0000,
        ST_RESP     = 11'b010_0000_0000,
        ST_SPARE    = 11'b100_0000_0000
    } t_state;

endpackage

`default_nettype wire

// File: sv/gsc_div.sv
// ----------------------------------------------------------------------------
// gsc_div
// Divider by the grid width: reciprocal multiply, then remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_div #(
    parameter int GRID_COLUMNS = 5
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [gsc_pkg::VAL_W-1:0]   i_dividend,
    output logic                       o_done,
    output logic [gsc_pkg::VAL_W-1:0]  o_quotient,
    output logic [$clog2(GRID_COLUMNS):0] o_remainder
);
    localparam int DW = $clog2(GRID_COLUMNS) + 1;
    localparam int VW = gsc_pkg::VAL_W;
    // shift of VW + DW bits keeps the quotient exact for every VW-bit dividend
    localparam int SH = VW + DW;
    localparam int MW = SH + 1;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(GRID_COLUMNS) - 64'd1) / 64'(GRID_COLUMNS));

    logic              r_pend;
    logic              r_done;
    logic [VW-1:0]     r_n;
    logic [VW-1:0]     r_q;
    logic [DW-1:0]     r_rem;
    logic [VW+MW-1:0]  prod;
    logic [VW-1:0]     back;

    assign prod = (VW+MW)'(i_dividend) * (VW+MW)'(RECIP);
    assign back = r_q * VW'(GRID_COLUMNS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pend <= i_start;
            r_done <= r_pend;
        end
    end

    // quotient first, remainder from it on the following cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n <= i_dividend;
            r_q <= prod[SH +: VW];
        end
        if (r_pend) begin
            r_rem <= DW'(r_n - back);
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// File: sv/grid_slot_cache_with_distance_eviction_top.sv
// ----------------------------------------------------------------------------
// grid_slot_cache_with_distance_eviction_top
// Slot cache for grid items with farthest-owner eviction and fetch picking.
// ----------------------------------------------------------------------------
// One request beat at a time gives one result beat. After reset the block
// sweeps the item-to-slot map memory clear, all MAX_ITEMS entries (1024 by
// default), and takes no request beat until that is done; the item_count
// register can be written meanwhile. An out-of-range request or the unused
// opcode goes straight to the result; a lookup or an install that reuses
// its own slot first reads the map, and an install into a free slot then
// also writes the slot. An install that must evict scans every slot owner,
// dividing each owner index by the grid width in a shared divider. A
// pick-next probes one candidate per cycle through the map memory read
// port. A result-side stall while the output register is full holds the
// result back. A finished result sits in the output register while the
// next request beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module grid_slot_cache_with_distance_eviction_top #(
    parameter int POOL_SLOTS   = 24,
    parameter int MAX_ITEMS    = 1024,
    parameter int GRID_COLUMNS = 5,
    parameter int VISIBLE_ROWS = 2,
    parameter int RING_LIMIT   = 400
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_op,
    input  wire  [9:0]  i_item_index,
    input  wire         i_upload_ok,
    input  wire  [9:0]  i_selected_index,
    input  wire  [7:0]  i_scroll_row,
    input  wire         i_fetch_busy,
    input  wire  [9:0]  i_fetch_index,
    // result channel
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_status,
    output logic        o_loaded,
    output logic [4:0]  o_slot,
    output logic        o_evicted_valid,
    output logic [9:0]  o_evicted_index,
    output logic        o_next_found,
    output logic [9:0]  o_next_index
);
    localparam int VW = gsc_pkg::VAL_W;
    localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int DW = $clog2(GRID_COLUMNS) + 1;
    localparam int KN = VISIBLE_ROWS * GRID_COLUMNS;
    localparam int KW = (KN > 1) ? $clog2(KN) : 1;
    localparam int RW = (RING_LIMIT > 1) ? $clog2(RING_LIMIT) : 1;

    gsc_pkg::t_state r_state, n_state;

    // configuration
    logic [10:0] r_item_count;
    logic [VW-1:0] cnt;

    // latched request
    logic [1:0]  r_op;
    logic [9:0]  r_item;
    logic        r_up_ok;
    logic [9:0]  r_sel;
    logic [7:0]  r_scroll;
    logic        r_fbusy;
    logic [9:0]  r_fidx;

    // slot state: owner memory plus per-slot flags
    logic [AW-1:0] mem_owner [POOL_SLOTS];
    logic [AW-1:0] r_own_rd;
    logic [POOL_SLOTS-1:0] r_own_v;
    logic [POOL_SLOTS-1:0] r_loaded;

    // item-to-slot map memory, entry = {valid, slot}
    logic [SW:0]   mem_map [MAX_ITEMS];
    logic [SW:0]   r_map_rd;
    logic [AW-1:0] map_raddr;
    logic          map_we;
    logic [AW-1:0] map_waddr;
    logic [SW:0]   map_wdata;
    logic [AW-1:0] r_clr;

    logic          own_re;
    logic [SW-1:0] own_raddr;

    // install / eviction
    logic          free_any;
    logic [SW-1:0] free_slot;
    logic [SW-1:0] r_tgt;
    logic [SW-1:0] r_scan;
    logic [SW-1:0] r_best;
    logic [AW-1:0] r_best_owner;
    logic [AW-1:0] r_cur_owner;
    logic [VW-1:0] r_best_d;
    logic          r_have;
    logic [VW-1:0] r_srow;
    logic [DW-1:0] r_scol;

    // divider
    logic          div_start;
    logic [VW-1:0] div_in;
    logic          div_done;
    logic [VW-1:0] div_q;
    logic [DW-1:0] div_r;

    logic          own_vis;
    logic [VW-1:0] own_d;
    logic [VW-1:0] row_diff;
    logic [DW-1:0] col_diff;

    // pick-next candidate generator and check stage
    logic          r_vis_phase;
    logic [KW-1:0] r_k;
    logic [RW-1:0] r_ring;
    logic          r_side;
    logic          r_gen_end;
    logic [VW-1:0] r_base;
    logic          r_chk_v;
    logic          r_chk_ok;
    logic          r_chk_nomem;
    logic [VW-1:0] r_chk_cand;
    logic [VW-1:0] cand;
    logic          cand_ok;
    logic          chk_hit;
    logic          pick_issue;

    // pending result and output register
    logic          r_res_status, r_res_loaded, r_res_ev_v, r_res_found;
    logic [4:0]    r_res_slot;
    logic [9:0]    r_res_ev_idx, r_res_next;
    logic          r_o_valid, r_o_status, r_o_loaded, r_o_ev_v, r_o_found;
    logic [4:0]    r_o_slot;
    logic [9:0]    r_o_ev_idx, r_o_next;

    logic          in_beat;
    logic          out_free;
    logic          cfg_wr;
    logic          map_v;
    logic [SW-1:0] map_s;
    logic          in_range;

    // ---------------------------------------------------------------------
    // Configuration port: one register, item_count, at byte address 0.
    // Counts above MAX_ITEMS act as MAX_ITEMS.
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == gsc_pkg::ADDR_ITEM_COUNT);
    assign prdata = (paddr == gsc_pkg::ADDR_ITEM_COUNT) ? {21'd0, r_item_count} : 32'd0;
    assign cnt = (VW'(r_item_count) > VW'(MAX_ITEMS)) ? VW'(MAX_ITEMS) : VW'(r_item_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= '0;
        end else if (cfg_wr) begin
            r_item_count <= pwdata[10:0];
        end
    end

    // ---------------------------------------------------------------------
    // Handshakes: take a request beat only when idle; hold a result in the
    // output register until the far side takes it.
    // ---------------------------------------------------------------------
    assign o_stall  = (r_state != gsc_pkg::ST_IDLE);
    assign in_beat  = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign in_range = (VW'(i_item_index) < cnt);

    assign map_v = r_map_rd[SW];
    assign map_s = r_map_rd[SW-1:0];

    // Lowest empty slot.
    always_comb begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
            if (!r_own_v[i]) begin
                free_any  = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Victim scoring: owner row/column come from the divider; an owner is
    // visible when it is listed and its row falls in the visible window.
    // ---------------------------------------------------------------------
    gsc_div #(
        .GRID_COLUMNS (GRID_COLUMNS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_in),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    always_comb begin
        own_vis  = (VW'(r_cur_owner) < cnt) && (div_q >= VW'(r_scroll))
                   && (div_q < VW'(r_scroll) + VW'(VISIBLE_ROWS));
        row_diff = (div_q > r_srow) ? (div_q - r_srow) : (r_srow - div_q);
        col_diff = (div_r > r_scol) ? (div_r - r_scol) : (r_scol - div_r);
        own_d    = row_diff + VW'(col_diff);
    end

    always_comb begin
        div_start = 1'b0;
        div_in    = VW'(r_sel);
        if (r_state == gsc_pkg::ST_MAP_CHK && r_op == gsc_pkg::OP_INSTALL
                && !map_v && !free_any) begin
            div_start = 1'b1;
        end else if (r_state == gsc_pkg::ST_SCAN_GO) begin
            div_start = 1'b1;
            div_in    = VW'(r_own_rd);
        end
    end

    // ---------------------------------------------------------------------
    // Pick-next: the visible cells first, then alternating rings around
    // the selection. Issue one map read per cycle; check it the next.
    // ---------------------------------------------------------------------
    always_comb begin
        if (r_vis_phase) begin
            cand    = r_base + VW'(r_k);
            cand_ok = (cand < cnt);
        end else if (!r_side) begin
            cand    = VW'(r_sel) + VW'(r_ring);
            cand_ok = (cand < cnt);
        end else begin
            cand    = VW'(r_sel) - VW'(r_ring);
            cand_ok = (VW'(r_ring) <= VW'(r_sel));
        end
    end

    assign chk_hit = r_chk_v && r_chk_ok
                     && !(!r_chk_nomem && map_v && r_loaded[map_s])
                     && !(r_fbusy && (VW'(r_fidx) == r_chk_cand));
    assign pick_issue = (r_state == gsc_pkg::ST_PICK) && !r_gen_end && !chk_hit;

    // ---------------------------------------------------------------------
    // Map memory port selection.
    // ---------------------------------------------------------------------
    always_comb begin
        map_raddr = AW'(VW'(i_item_index));
        if (r_state == gsc_pkg::ST_PICK) begin
            map_raddr = cand[AW-1:0];
        end
    end

    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_clr;
        map_wdata = '0;
        case (r_state)
            gsc_pkg::ST_CLEAR: begin
                map_we = 1'b1;
            end
            gsc_pkg::ST_EVICT: begin
                map_we    = 1'b1;
                map_waddr = r_best_owner;
            end
            gsc_pkg::ST_INSTALL: begin
                map_we    = 1'b1;
                map_waddr = AW'(VW'(r_item));
                map_wdata = {1'b1, r_tgt};
            end
            default: begin
                map_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[map_waddr] <= map_wdata;
        end
        r_map_rd <= mem_map[map_raddr];
    end

    // Owner memory: read one slot per scan step, write on install.
    always_comb begin
        own_re    = 1'b0;
        own_raddr = '0;
        if (r_state == gsc_pkg::ST_SEL_DIV && div_done) begin
            own_re = 1'b1;
        end else if (r_state == gsc_pkg::ST_SCAN_DIV && div_done
                && r_scan != SW'(POOL_SLOTS - 1)) begin
            own_re    = 1'b1;
            own_raddr = r_scan + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gsc_pkg::ST_INSTALL) begin
            mem_owner[r_tgt] <= AW'(VW'(r_item));
        end
        if (own_re) begin
            r_own_rd <= mem_owner[own_raddr];
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            gsc_pkg::ST_CLEAR: begin
                if (r_clr == AW'(MAX_ITEMS - 1)) n_state = gsc_pkg::ST_IDLE;
            end
            gsc_pkg::ST_IDLE: begin
                if (in_beat) begin
                    if (i_op == gsc_pkg::OP_PICK) begin
                        n_state = gsc_pkg::ST_PICK;
                    end else if ((i_op == gsc_pkg::OP_INSTALL || i_op == gsc_pkg::OP_LOOKUP)
                            && in_range) begin
                        n_state = gsc_pkg::ST_MAP_CHK;
                    end else begin
                        n_state = gsc_pkg::ST_RESP;
                    end
                end
            end
            gsc_pkg::ST_MAP_CHK: begin
                if (r_op == gsc_pkg::OP_LOOKUP || map_v) n_state = gsc_pkg::ST_RESP;
                else if (free_any)                       n_state = gsc_pkg::ST_INSTALL;
                else                                     n_state = gsc_pkg::ST_SEL_DIV;
            end
            gsc_pkg::ST_SEL_DIV: begin
                if (div_done) n_state = gsc_pkg::ST_SCAN_GO;
            end
            gsc_pkg::ST_SCAN_GO: begin
                n_state = gsc_pkg::ST_SCAN_DIV;
            end
            gsc_pkg::ST_SCAN_DIV: begin
                if (div_done) begin
                    if (r_scan == SW'(POOL_SLOTS - 1)) n_state = gsc_pkg::ST_EVICT;
                    else                               n_state = gsc_pkg::ST_SCAN_GO;
                end
            end
            gsc_pkg::ST_EVICT: begin
                n_state = gsc_pkg::ST_INSTALL;
            end
            gsc_pkg::ST_INSTALL: begin
                n_state = gsc_pkg::ST_RESP;
            end
            gsc_pkg::ST_PICK: begin
                if (chk_hit || r_gen_end) n_state = gsc_pkg::ST_RESP;
            end
            gsc_pkg::ST_RESP: begin
                if (out_free) n_state = gsc_pkg::ST_IDLE;
            end
            default: begin
                n_state = gsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsc_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_own_v <= '0;
            r_loaded <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == gsc_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            // reuse of an existing slot: only the loaded flag changes
            if (r_state == gsc_pkg::ST_MAP_CHK && r_op == gsc_pkg::OP_INSTALL && map_v) begin
                r_loaded[map_s] <= r_up_ok;
            end
            if (r_state == gsc_pkg::ST_INSTALL) begin
                r_own_v[r_tgt]  <= 1'b1;
                r_loaded[r_tgt] <= r_up_ok;
            end
        end
    end

    // Request latch, scan bookkeeping and pending result.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_op     <= i_op;
            r_item   <= i_item_index;
            r_up_ok  <= i_upload_ok;
            r_sel    <= i_selected_index;
            r_scroll <= i_scroll_row;
            r_fbusy  <= i_fetch_busy;
            r_fidx   <= i_fetch_index;
            r_base   <= VW'(i_scroll_row) * VW'(GRID_COLUMNS);
            r_res_status <= (i_op == gsc_pkg::OP_INSTALL || i_op == gsc_pkg::OP_LOOKUP)
                            && !in_range;
            r_res_loaded <= 1'b0;
            r_res_slot   <= '0;
            r_res_ev_v   <= 1'b0;
            r_res_ev_idx <= '0;
            r_res_found  <= 1'b0;
            r_res_next   <= '0;
        end

        case (r_state)
            gsc_pkg::ST_MAP_CHK: begin
                if (r_op == gsc_pkg::OP_LOOKUP) begin
                    r_res_loaded <= map_v && r_loaded[map_s];
                    r_res_slot   <= map_v ? 5'(VW'(map_s)) : 5'd0;
                end else if (map_v) begin
                    r_res_loaded <= r_up_ok;
                    r_res_slot   <= 5'(VW'(map_s));
                end
                r_tgt <= free_slot;
            end
            gsc_pkg::ST_SEL_DIV: begin
                if (div_done) begin
                    r_srow <= div_q;
                    r_scol <= div_r;
                    r_scan <= '0;
                end
            end
            gsc_pkg::ST_SCAN_GO: begin
                r_cur_owner <= r_own_rd;
            end
            gsc_pkg::ST_SCAN_DIV: begin
                if (div_done) begin
                    // slot 0 seeds the search; a later non-visible slot wins when farther or when none is held yet
                    if (r_scan == '0) begin
                        r_best       <= '0;
                        r_best_owner <= r_cur_owner;
                        r_best_d     <= own_d;
                        r_have       <= !own_vis;
                    end else if (!own_vis && (!r_have || own_d > r_best_d)) begin
                        r_best       <= r_scan;
                        r_best_owner <= r_cur_owner;
                        r_best_d     <= own_d;
                        r_have       <= 1'b1;
                    end
                    r_scan <= r_scan + 1'b1;
                end
            end
            gsc_pkg::ST_EVICT: begin
                r_tgt        <= r_best;
                r_res_ev_v   <= 1'b1;
                r_res_ev_idx <= 10'(VW'(r_best_owner));
            end
            gsc_pkg::ST_INSTALL: begin
                r_res_loaded <= r_up_ok;
                r_res_slot   <= 5'(VW'(r_tgt));
            end
            gsc_pkg::ST_PICK: begin
                if (chk_hit) begin
                    r_res_found <= 1'b1;
                    r_res_next  <= r_chk_cand[9:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Candidate generator and check stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_v   <= 1'b0;
            r_gen_end <= 1'b0;
        end else if (in_beat) begin
            r_vis_phase <= 1'b1;
            r_k         <= '0;
            r_ring      <= RW'(1);
            r_side      <= 1'b0;
            r_gen_end   <= 1'b0;
            r_chk_v     <= 1'b0;
        end else begin
            r_chk_v     <= pick_issue;
            r_chk_ok    <= cand_ok;
            r_chk_nomem <= (cand >= VW'(MAX_ITEMS));
            r_chk_cand  <= cand;
            if (pick_issue) begin
                if (r_vis_phase) begin
                    if (r_k == KW'(KN - 1)) begin
                        if (RING_LIMIT > 1) r_vis_phase <= 1'b0;
                        else                r_gen_end   <= 1'b1;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end else if (!r_side) begin
                    r_side <= 1'b1;
                end else if (r_ring == RW'(RING_LIMIT - 1)) begin
                    r_gen_end <= 1'b1;
                end else begin
                    r_ring <= r_ring + 1'b1;
                    r_side <= 1'b0;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == gsc_pkg::ST_RESP && out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
        if (r_state == gsc_pkg::ST_RESP && out_free) begin
            r_o_status <= r_res_status;
            r_o_loaded <= r_res_loaded;
            r_o_slot   <= r_res_slot;
            r_o_ev_v   <= r_res_ev_v;
            r_o_ev_idx <= r_res_ev_idx;
            r_o_found  <= r_res_found;
            r_o_next   <= r_res_next;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_loaded        = r_o_loaded;
    assign o_slot          = r_o_slot;
    assign o_evicted_valid = r_o_ev_v;
    assign o_evicted_index = r_o_ev_idx;
    assign o_next_found    = r_o_found;
    assign o_next_index    = r_o_next;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    `ASSERT_NOW(a_evict_only_full, r_state == gsc_pkg::ST_EVICT, &r_own_v,
        "eviction with an empty slot available")
    `ASSERT_NEXT(a_install_fills, r_state == gsc_pkg::ST_INSTALL,
        r_own_v[$past(r_tgt)] && r_loaded[$past(r_tgt)] == $past(r_up_ok),
        "install did not claim its slot")
    `ASSERT_NOW(a_status_alone, o_valid && o_status,
        !o_loaded && !o_evicted_valid && !o_next_found,
        "ignored request carries result fields")

endmodule

`default_nettype wire
